>>> src/lpht_pkg.sv
// Shared constants, codes and types of the linear probing hash table.
// Depends on nothing; every other file of the block uses it by scoped names.
package lpht_pkg;

   localparam int TABLE_SIZE  = 16;
   localparam int IDX_BITS    = $clog2(TABLE_SIZE);
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int COUNT_BITS  = 5;
   localparam int MODE_BITS   = 2;
   localparam int STATUS_BITS = 3;
   localparam int MARK_BITS   = 2;

   typedef logic [IDX_BITS-1:0]    idx_type;
   typedef logic [KEY_BITS-1:0]    key_type;
   typedef logic [VALUE_BITS-1:0]  value_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [MODE_BITS-1:0]   mode_type;
   typedef logic [STATUS_BITS-1:0] status_type;
   typedef logic [MARK_BITS-1:0]   mark_type;

   localparam count_type FILL_LIMIT_RESET = 5'd11;
   localparam idx_type   LAST_STEP        = idx_type'(TABLE_SIZE - 1);

   localparam mode_type MODE_PUT    = 2'd0;
   localparam mode_type MODE_GET    = 2'd1;
   localparam mode_type MODE_DELETE = 2'd2;

   localparam status_type STATUS_INSERTED  = 3'd0;
   localparam status_type STATUS_UPDATED   = 3'd1;
   localparam status_type STATUS_FOUND     = 3'd2;
   localparam status_type STATUS_NOT_FOUND = 3'd3;
   localparam status_type STATUS_DELETED   = 3'd4;
   localparam status_type STATUS_FULL      = 3'd5;

   localparam mark_type MARK_EMPTY = 2'd0;
   localparam mark_type MARK_LIVE  = 2'd1;
   localparam mark_type MARK_TOMB  = 2'd2;

   // One write into the slot store: key, value and mark each have an enable.
   typedef struct packed {
      logic      key_en;
      logic      value_en;
      logic      mark_en;
      idx_type   addr;
      key_type   key;
      value_type value;
      mark_type  mark;
   } wr_type;

endpackage

>>> src/lpht_chan_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on lpht_pkg for the payload types.
interface lpht_req_if;
   logic                 valid;
   logic                 ready;
   lpht_pkg::mode_type   mode;
   lpht_pkg::key_type    key;
   lpht_pkg::value_type  value;

   modport source (output valid, output mode, output key, output value, input ready);
   modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface lpht_rsp_if;
   logic                   valid;
   logic                   ready;
   lpht_pkg::status_type   status;
   lpht_pkg::value_type    read_value;
   lpht_pkg::count_type    entry_count;

   modport source (output valid, output status, output read_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input read_value, input entry_count,
                   output ready);
endinterface

>>> src/lpht_slot_store.sv
// Slot storage: key and value memories with a registered read port, and
// the per-slot marks in flip-flops that reset to empty. Depends on lpht_pkg.
module lpht_slot_store (
   input  logic                clock,
   input  logic                reset,
   input  lpht_pkg::idx_type   rd_addr,
   input  lpht_pkg::idx_type   mark_addr,
   input  lpht_pkg::wr_type    wr,
   output lpht_pkg::key_type   key_rd,
   output lpht_pkg::value_type value_rd,
   output lpht_pkg::mark_type  mark_rd
);

   lpht_pkg::key_type   slot_keys_ff   [lpht_pkg::TABLE_SIZE];
   lpht_pkg::value_type slot_values_ff [lpht_pkg::TABLE_SIZE];
   lpht_pkg::mark_type  slot_marks_ff  [lpht_pkg::TABLE_SIZE];
   lpht_pkg::key_type   key_rd_ff;
   lpht_pkg::value_type value_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.key_en) begin
         slot_keys_ff[wr.addr] <= wr.key;
      end
      if (wr.value_en) begin
         slot_values_ff[wr.addr] <= wr.value;
      end
      key_rd_ff   <= slot_keys_ff[rd_addr];
      value_rd_ff <= slot_values_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lpht_pkg::TABLE_SIZE; i++) begin
            slot_marks_ff[i] <= lpht_pkg::MARK_EMPTY;
         end
      end else if (wr.mark_en) begin
         slot_marks_ff[wr.addr] <= wr.mark;
      end
   end

   assign key_rd   = key_rd_ff;
   assign value_rd = value_rd_ff;
   assign mark_rd  = slot_marks_ff[mark_addr];

endmodule

>>> src/linear_probe_hash_table.sv
// Top level of the linear probing hash table: probe sequencer and response register.
// Depends on lpht_pkg, the channel interfaces and lpht_slot_store.

// The table holds up to 16 key/value pairs with open addressing. A put, get
// or delete item starts its probe at the slot given by the low key bits and
// walks forward one slot per clock, wrapping at the end, through the single
// read port of the key and value store. The probe ends at the matching live
// slot, at an empty slot, or after all 16 slots. Tombstones left by deletes
// are stepped over by every probe, and a put of a new key lands in the first
// tombstone it passed, else in the empty slot that stopped it. A put of a new
// key is answered as full once the entry count has reached the fill limit
// register or no free slot exists; updates of present keys always succeed.
// An item is accepted only while the sequencer is idle, and the block stays
// busy until its probe has finished, so it cannot take a new item before it
// is through with the last one and has gone back to idle.
// The result item is held in an output register, so the next item can be
// accepted while a result still waits; the sequencer only stalls when it
// finishes a probe while the previous result has not yet been taken. The
// slot marks reset to empty at once, so no clearing pass follows reset. The
// fill limit may be written whenever the block is idle.
module linear_probe_hash_table (
   input  logic                clock,
   input  logic                reset,
   lpht_req_if.sink            req_chan,
   lpht_rsp_if.source          rsp_chan,
   input  logic                csr_wr_en,
   input  lpht_pkg::count_type csr_wr_data
);

   typedef enum logic {
      ST_IDLE,
      ST_PROBE
   } state_type;

   state_type            state_ff, state_in;
   lpht_pkg::mode_type   mode_ff, mode_in;
   lpht_pkg::key_type    key_ff, key_in;
   lpht_pkg::value_type  value_ff, value_in;
   lpht_pkg::idx_type    idx_ff, idx_in;
   lpht_pkg::idx_type    step_ff, step_in;
   logic                 tomb_seen_ff, tomb_seen_in;
   lpht_pkg::idx_type    tomb_idx_ff, tomb_idx_in;
   lpht_pkg::count_type  count_ff, count_in;
   lpht_pkg::count_type  limit_ff, limit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lpht_pkg::status_type rsp_status_ff, rsp_status_in;
   lpht_pkg::value_type  rsp_read_value_ff, rsp_read_value_in;
   lpht_pkg::count_type  rsp_count_ff, rsp_count_in;

   lpht_pkg::idx_type    rd_addr;
   lpht_pkg::wr_type     wr;
   lpht_pkg::key_type    key_rd;
   lpht_pkg::value_type  value_rd;
   lpht_pkg::mark_type   mark_rd;

   logic                 accept;
   logic                 hit;
   logic                 is_empty;
   logic                 is_tomb;
   logic                 probe_done;
   logic                 out_free;
   logic                 finish;
   logic                 free_valid;
   lpht_pkg::idx_type    free_idx;

   lpht_slot_store u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (rd_addr),
      .mark_addr (idx_ff),
      .wr        (wr),
      .key_rd    (key_rd),
      .value_rd  (value_rd),
      .mark_rd   (mark_rd)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // The slot under test this cycle is idx_ff; its key and value were read
   // at the previous edge, its mark comes straight from the flip-flops.
   assign is_empty   = (mark_rd == lpht_pkg::MARK_EMPTY);
   assign is_tomb    = (mark_rd == lpht_pkg::MARK_TOMB);
   assign hit        = (mark_rd == lpht_pkg::MARK_LIVE) && (key_rd == key_ff);
   assign probe_done = (state_ff == ST_PROBE) &&
                       (hit || is_empty || (step_ff == lpht_pkg::LAST_STEP));
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign finish     = probe_done && out_free;

   // A tombstone on the final slot still counts as the first one seen.
   assign free_valid = tomb_seen_ff || is_tomb || is_empty;
   assign free_idx   = tomb_seen_ff ? tomb_idx_ff : idx_ff;

   // The read address runs one slot ahead of the slot being checked, and
   // holds on the current slot while a finished probe waits for the output.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         rd_addr = req_chan.key[lpht_pkg::IDX_BITS-1:0];
      end else if (probe_done && !out_free) begin
         rd_addr = idx_ff;
      end else begin
         rd_addr = idx_ff + 1'b1;
      end
   end

   always_comb begin
      state_in          = state_ff;
      mode_in           = mode_ff;
      key_in            = key_ff;
      value_in          = value_ff;
      idx_in            = idx_ff;
      step_in           = step_ff;
      tomb_seen_in      = tomb_seen_ff;
      tomb_idx_in       = tomb_idx_ff;
      count_in          = count_ff;
      limit_in          = csr_wr_en ? csr_wr_data : limit_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in     = rsp_status_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_count_in      = rsp_count_ff;

      wr          = '0;
      wr.addr     = idx_ff;
      wr.key      = key_ff;
      wr.value    = value_ff;
      wr.mark     = lpht_pkg::MARK_LIVE;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in      = req_chan.mode;
               key_in       = req_chan.key;
               value_in     = req_chan.value;
               idx_in       = req_chan.key[lpht_pkg::IDX_BITS-1:0];
               step_in      = '0;
               tomb_seen_in = 1'b0;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (!probe_done) begin
               idx_in  = idx_ff + 1'b1;
               step_in = step_ff + 1'b1;
               if (is_tomb && !tomb_seen_ff) begin
                  tomb_seen_in = 1'b1;
                  tomb_idx_in  = idx_ff;
               end
            end else if (finish) begin
               state_in          = ST_IDLE;
               rsp_valid_in      = 1'b1;
               rsp_status_in     = lpht_pkg::STATUS_NOT_FOUND;
               rsp_read_value_in = '0;
               unique case (mode_ff)
                  lpht_pkg::MODE_PUT: begin
                     if (hit) begin
                        wr.value_en   = 1'b1;
                        rsp_status_in = lpht_pkg::STATUS_UPDATED;
                     end else if ((count_ff >= limit_ff) || !free_valid) begin
                        rsp_status_in = lpht_pkg::STATUS_FULL;
                     end else begin
                        wr.addr       = free_idx;
                        wr.key_en     = 1'b1;
                        wr.value_en   = 1'b1;
                        wr.mark_en    = 1'b1;
                        count_in      = count_ff + 1'b1;
                        rsp_status_in = lpht_pkg::STATUS_INSERTED;
                     end
                  end
                  lpht_pkg::MODE_GET: begin
                     if (hit) begin
                        rsp_read_value_in = value_rd;
                        rsp_status_in     = lpht_pkg::STATUS_FOUND;
                     end
                  end
                  lpht_pkg::MODE_DELETE: begin
                     if (hit) begin
                        wr.mark_en    = 1'b1;
                        wr.mark       = lpht_pkg::MARK_TOMB;
                        if (count_ff != '0) begin
                           count_in = count_ff - 1'b1;
                        end
                        rsp_status_in = lpht_pkg::STATUS_DELETED;
                     end
                  end
                  default: begin
                     // The unused mode changes nothing and reports not found.
                     rsp_status_in = lpht_pkg::STATUS_NOT_FOUND;
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         limit_ff     <= lpht_pkg::FILL_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff           <= mode_in;
      key_ff            <= key_in;
      value_ff          <= value_in;
      idx_ff            <= idx_in;
      step_ff           <= step_in;
      tomb_seen_ff      <= tomb_seen_in;
      tomb_idx_ff       <= tomb_idx_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_count_ff      <= rsp_count_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.read_value  = rsp_read_value_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

endmodule
